### hw/rtl/vpd_pkg.sv
// ----------------------------------------------------------------------------
// vpd_pkg
// Shared types and sizes for the corner pair welding table.
// ----------------------------------------------------------------------------
package vpd_pkg;

  localparam int unsigned TABLE_DEPTH = 4096;
  localparam int unsigned NUM_CELLS   = 8;
  localparam int unsigned BANK_DEPTH  = TABLE_DEPTH / NUM_CELLS;

  localparam int unsigned POS_W  = 12;
  localparam int unsigned TEX_W  = 16;
  localparam int unsigned KEY_W  = POS_W + TEX_W;
  localparam int unsigned SLOT_W = 12;
  localparam int unsigned LANE_W = $clog2(NUM_CELLS);
  localparam int unsigned ROW_W  = $clog2(BANK_DEPTH);
  localparam int unsigned CNT_W  = $clog2(TABLE_DEPTH) + 1;

  typedef struct packed {
    logic [POS_W-1:0] position_index;
    logic [TEX_W-1:0] texcoord_index;
    logic             mesh_start;
  } in_word_t;

  typedef struct packed {
    logic [SLOT_W-1:0] unique_slot;
    logic              was_added;
    logic              overflow;
  } out_word_t;

  typedef struct packed {
    logic              hit;
    logic [LANE_W-1:0] lane;
  } chain_t;

endpackage

### hw/rtl/vpd_ram.sv
// ----------------------------------------------------------------------------
// vpd_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module vpd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/vpd_cell.sv
// ----------------------------------------------------------------------------
// vpd_cell
// One lane of the table: owns a bank of slots, compares the bank's row
// against the search key and passes the first hit down the chain.
// ----------------------------------------------------------------------------
module vpd_cell (
  input  logic                          clk_i,
  input  logic [vpd_pkg::LANE_W-1:0]    lane_i,
  input  logic                          wr_en_i,
  input  logic [vpd_pkg::LANE_W-1:0]    wr_lane_i,
  input  logic [vpd_pkg::ROW_W-1:0]     wr_row_i,
  input  logic [vpd_pkg::KEY_W-1:0]     key_i,
  input  logic [vpd_pkg::ROW_W-1:0]     rd_row_i,
  input  logic                          cmp_en_i,
  input  logic [vpd_pkg::ROW_W-1:0]     cmp_row_i,
  input  logic [vpd_pkg::CNT_W-1:0]     count_i,
  input  vpd_pkg::chain_t               chain_i,
  output vpd_pkg::chain_t               chain_o
);
  import vpd_pkg::*;

  logic             bank_we;
  logic [KEY_W-1:0] bank_data;
  logic             slot_valid;
  logic             own_hit;

  assign bank_we = wr_en_i && (wr_lane_i == lane_i);

  vpd_ram #(
    .WIDTH(KEY_W),
    .DEPTH(BANK_DEPTH)
  ) u_bank (
    .clk_i  (clk_i),
    .we_i   (bank_we),
    .waddr_i(wr_row_i),
    .wdata_i(key_i),
    .raddr_i(rd_row_i),
    .rdata_o(bank_data)
  );

  // slot is live only below the fill count
  assign slot_valid = {1'b0, cmp_row_i, lane_i} < count_i;
  assign own_hit    = cmp_en_i && slot_valid && (bank_data == key_i);

  always_comb begin
    chain_o.hit  = chain_i.hit || own_hit;
    chain_o.lane = chain_i.hit ? chain_i.lane : lane_i;
  end

endmodule

### hw/rtl/vertex_pair_dedup_top.sv
// ----------------------------------------------------------------------------
// vertex_pair_dedup_top
// Corner pair welding table: returns the slot of a (position, texcoord) pair,
// appending it on first sight within the current mesh.
// ----------------------------------------------------------------------------
// One word in gives one word out. The table is split over a chain of eight
// cells, each with its own RAM bank; slot s lives in cell s mod 8 at row s/8,
// and all cells compare one row per cycle. A corner scans ceil(entries/8)
// rows when the pair is missing and fewer when it is found early, so a full
// table of 4096 entries needs up to 512 rows of compares. One
// corner is searched at a time; the result register lets the next corner be
// taken while the previous result waits. No clearing pass: only slots below
// the fill count are ever compared.
module vertex_pair_dedup_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  vpd_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output vpd_pkg::out_word_t out_word_o
);
  import vpd_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [ROW_W:0]   issue_q, issue_d;
  logic             rd_vld_q, rd_vld_d;
  logic [ROW_W-1:0] row_q;
  logic [CNT_W-1:0] count_q, count_d;
  logic [KEY_W-1:0] key_q;
  out_word_t        res_q, res_d;
  logic             out_valid_q, out_valid_d;
  out_word_t        out_word_q;

  logic             in_acc;
  logic [CNT_W-1:0] count_round;
  logic [ROW_W:0]   num_rows;
  logic             issue;
  logic             scan_hit;
  logic             scan_miss;
  logic             table_full;
  logic             wr_en;
  logic             out_load;

  chain_t chain [NUM_CELLS+1];

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign count_round = count_q + CNT_W'(NUM_CELLS - 1);
  assign num_rows    = count_round[CNT_W-1:LANE_W];
  assign table_full  = (count_q == CNT_W'(TABLE_DEPTH));

  assign scan_hit  = (state_q == S_SCAN) && rd_vld_q && chain[NUM_CELLS].hit;
  assign scan_miss = (state_q == S_SCAN) && !scan_hit &&
                     ((count_q == '0) ||
                      (rd_vld_q && ({1'b0, row_q} == num_rows - 1'b1)));
  assign issue     = (state_q == S_SCAN) && (issue_q < num_rows);
  assign wr_en     = scan_miss && !table_full;
  assign out_load  = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  assign chain[0] = '0;

  for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
    vpd_cell u_cell (
      .clk_i    (clk_i),
      .lane_i   (LANE_W'(g)),
      .wr_en_i  (wr_en),
      .wr_lane_i(count_q[LANE_W-1:0]),
      .wr_row_i (count_q[SLOT_W-1:LANE_W]),
      .key_i    (key_q),
      .rd_row_i (issue_q[ROW_W-1:0]),
      .cmp_en_i (rd_vld_q),
      .cmp_row_i(row_q),
      .count_i  (count_q),
      .chain_i  (chain[g]),
      .chain_o  (chain[g+1])
    );
  end

  always_comb begin
    state_d     = state_q;
    issue_d     = issue_q;
    rd_vld_d    = 1'b0;
    count_d     = count_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          issue_d = '0;
          state_d = S_SCAN;
          if (in_word_i.mesh_start) begin
            count_d = '0;
          end
        end
      end
      S_SCAN: begin
        if (issue) begin
          issue_d  = issue_q + 1'b1;
          rd_vld_d = 1'b1;
        end
        if (scan_hit) begin
          res_d.unique_slot = {row_q, chain[NUM_CELLS].lane};
          res_d.was_added   = 1'b0;
          res_d.overflow    = 1'b0;
          rd_vld_d          = 1'b0;
          state_d           = S_DONE;
        end else if (scan_miss) begin
          rd_vld_d = 1'b0;
          state_d  = S_DONE;
          if (table_full) begin
            res_d.unique_slot = '0;
            res_d.was_added   = 1'b0;
            res_d.overflow    = 1'b1;
          end else begin
            res_d.unique_slot = count_q[SLOT_W-1:0];
            res_d.was_added   = 1'b1;
            res_d.overflow    = 1'b0;
            count_d           = count_q + 1'b1;
          end
        end
      end
      S_DONE: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      issue_q     <= '0;
      rd_vld_q    <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      issue_q     <= issue_d;
      rd_vld_q    <= rd_vld_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      key_q <= {in_word_i.position_index, in_word_i.texcoord_index};
    end
    if (issue) begin
      row_q <= issue_q[ROW_W-1:0];
    end
    res_q <= res_d;
    if (out_load) begin
      out_word_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // fill count never passes the table size
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(TABLE_DEPTH))
    else $error("fill count above table size");

  // an overflow word carries slot zero and no append
  a_ovf_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.overflow |-> !out_word_o.was_added &&
      (out_word_o.unique_slot == '0))
    else $error("overflow word with slot or append set");

  // an append moves the fill count by exactly one
  a_append_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |=> count_q == $past(count_q) + 1'b1)
    else $error("append did not advance fill count");

  // an accepted corner always starts a search
  a_accept_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == S_SCAN)
    else $error("accepted corner did not start a search");

endmodule

### dv/tb_vertex_pair_dedup_top.sv
// ----------------------------------------------------------------------------
// tb_vertex_pair_dedup_top
// Self-checking bench for the corner pair welding table. A short table of
// corners covers field extremes, repeats and mesh starts. Random meshes built
// from small pools of pairs and near misses follow, and a last stretch runs
// with no gaps. Every result word is compared field by field with its typed
// result or else a welding predictor. Random gaps are put on both handshakes.
// ----------------------------------------------------------------------------
module tb_vertex_pair_dedup_top;
  import vpd_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int TAIL_CYCLES    = 600;
  localparam int RANDOM_ITEMS   = 220;

  typedef struct packed {
    in_word_t  corner;
    logic      typed;
    out_word_t result;
  } corner_row_t;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  in_word_t  in_word_i   = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_word_t out_word_o;

  logic [KEY_W-1:0] welded_pairs [TABLE_DEPTH];
  int               pair_count  = 0;
  out_word_t        expected_welds [$];
  int               weld_errors = 0;
  logic             idling_on   = 1'b1;
  int               ready_hold  = 0;
  int               quiet_cycles = 0;

  // position, texcoord, start | typed | slot, added, overflow
  corner_row_t corner_rows [22] = '{
    {12'h000, 16'h0000, 1'b0, 1'b1, 12'd0, 1'b1, 1'b0},
    {12'hFFF, 16'hFFFF, 1'b0, 1'b1, 12'd1, 1'b1, 1'b0},
    {12'h000, 16'h0000, 1'b0, 1'b1, 12'd0, 1'b0, 1'b0},
    {12'hFFF, 16'h0000, 1'b0, 1'b1, 12'd2, 1'b1, 1'b0},
    {12'h000, 16'hFFFF, 1'b0, 1'b1, 12'd3, 1'b1, 1'b0},
    {12'hFFF, 16'hFFFF, 1'b0, 1'b1, 12'd1, 1'b0, 1'b0},
    {12'hAAA, 16'h5555, 1'b0, 1'b1, 12'd4, 1'b1, 1'b0},
    {12'h555, 16'hAAAA, 1'b0, 1'b1, 12'd5, 1'b1, 1'b0},
    {12'hAAA, 16'hAAAA, 1'b0, 1'b1, 12'd6, 1'b1, 1'b0},
    {12'hAAA, 16'h5555, 1'b0, 1'b1, 12'd4, 1'b0, 1'b0},
    {12'hFFF, 16'hFFFF, 1'b1, 1'b1, 12'd0, 1'b1, 1'b0},
    {12'h000, 16'h0000, 1'b0, 1'b1, 12'd1, 1'b1, 1'b0},
    {12'hFFF, 16'hFFFF, 1'b0, 1'b1, 12'd0, 1'b0, 1'b0},
    {12'h001, 16'h0001, 1'b0, 1'b0, 12'd0, 1'b0, 1'b0},
    {12'h800, 16'h8000, 1'b0, 1'b0, 12'd0, 1'b0, 1'b0},
    {12'h001, 16'h0001, 1'b0, 1'b0, 12'd0, 1'b0, 1'b0},
    {12'h800, 16'h8000, 1'b1, 1'b1, 12'd0, 1'b1, 1'b0},
    {12'h800, 16'h8000, 1'b1, 1'b1, 12'd0, 1'b1, 1'b0},
    {12'h800, 16'h8000, 1'b0, 1'b1, 12'd0, 1'b0, 1'b0},
    {12'h7FF, 16'h7FFF, 1'b0, 1'b0, 12'd0, 1'b0, 1'b0},
    {12'h800, 16'h7FFF, 1'b0, 1'b0, 12'd0, 1'b0, 1'b0},
    {12'h7FF, 16'h8000, 1'b0, 1'b0, 12'd0, 1'b0, 1'b0}
  };

  vertex_pair_dedup_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic out_word_t weld_corner(in_word_t corner);
    logic [KEY_W-1:0] key;
    out_word_t        res;
    logic             found;
    key   = {corner.position_index, corner.texcoord_index};
    res   = '0;
    found = 1'b0;
    if (corner.mesh_start) pair_count = 0;
    for (int s = 0; s < pair_count; s++) begin
      if (!found && welded_pairs[s] == key) begin
        res.unique_slot = SLOT_W'(s);
        found = 1'b1;
      end
    end
    if (!found) begin
      if (pair_count >= int'(TABLE_DEPTH)) begin
        res.overflow = 1'b1;
      end else begin
        welded_pairs[pair_count] = key;
        res.unique_slot = SLOT_W'(pair_count);
        res.was_added   = 1'b1;
        pair_count++;
      end
    end
    return res;
  endfunction

  function automatic in_word_t random_corner(logic start);
    in_word_t w;
    w.position_index = POS_W'($urandom);
    w.texcoord_index = TEX_W'($urandom);
    w.mesh_start     = start;
    return w;
  endfunction

  task automatic send_corner(input in_word_t corner, input logic typed = 1'b0,
                             input out_word_t typed_result = '0);
    int        gap;
    out_word_t predicted;
    gap = (idling_on && $urandom_range(0, 3) == 0) ? int'($urandom_range(1, 7)) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= corner;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = weld_corner(corner);
    expected_welds.push_back(typed ? typed_result : predicted);
  endtask

  // a mesh drawn mostly from a small pool of pairs, some of them one bit apart
  task automatic send_mesh(input int mesh_len);
    in_word_t pool [16];
    int       pool_len;
    int       roll;
    in_word_t c;
    pool_len = $urandom_range(1, 16);
    for (int k = 0; k < pool_len; k++) begin
      pool[k] = random_corner(1'b0);
      if (k > 0 && $urandom_range(0, 2) == 0) begin
        pool[k] = pool[$urandom_range(0, k - 1)];
        if ($urandom_range(0, 1) == 1)
          pool[k].texcoord_index ^= TEX_W'(1) << $urandom_range(0, TEX_W - 1);
        else
          pool[k].position_index ^= POS_W'(1) << $urandom_range(0, POS_W - 1);
      end
    end
    for (int n = 0; n < mesh_len; n++) begin
      roll = $urandom_range(0, 19);
      if (roll < 17) c = pool[$urandom_range(0, pool_len - 1)];
      else c = random_corner(roll == 19);
      if (n == 0) c.mesh_start = 1'b1;
      send_corner(c);
    end
  endtask

  always @(posedge clk_i) begin
    if (!idling_on) begin
      ready_hold = 0;
      out_ready_i <= 1'b1;
    end else if (ready_hold > 0) begin
      ready_hold--;
    end else if ($urandom_range(0, 5) == 0) begin
      out_ready_i <= 1'b0;
      ready_hold = $urandom_range(0, 6);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_welds.size() == 0) begin
        if (weld_errors < 10)
          $display("%0t: result word with none expected: slot %0d added %0b overflow %0b",
                   $realtime, out_word_o.unique_slot, out_word_o.was_added,
                   out_word_o.overflow);
        weld_errors++;
      end else begin
        want = expected_welds.pop_front();
        if (out_word_o.unique_slot !== want.unique_slot ||
            out_word_o.was_added !== want.was_added ||
            out_word_o.overflow !== want.overflow) begin
          if (weld_errors < 10)
            $display("%0t: expected slot %0d added %0b overflow %0b, %s %0d %s %0b %s %0b",
                     $realtime, want.unique_slot, want.was_added, want.overflow,
                     "got slot", out_word_o.unique_slot, "added", out_word_o.was_added,
                     "overflow", out_word_o.overflow);
          weld_errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("vertex_pair_dedup_top test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int       random_sent;
    int       mesh_len;
    random_sent = 0;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (corner_rows[r])
      send_corner(corner_rows[r].corner, corner_rows[r].typed, corner_rows[r].result);

    while (random_sent < RANDOM_ITEMS) begin
      idling_on = ($urandom_range(0, 3) != 0);
      mesh_len  = ($urandom_range(0, 7) == 0) ? int'($urandom_range(60, 150))
                                              : int'($urandom_range(1, 40));
      send_mesh(mesh_len);
      random_sent += mesh_len;
    end

    // hold off until every result is back
    in_valid_i <= 1'b0;
    while (expected_welds.size() != 0) @(posedge clk_i);

    idling_on = 1'b0;
    repeat (3) send_mesh($urandom_range(8, 20));
    in_valid_i <= 1'b0;

    while (expected_welds.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (weld_errors == 0 && expected_welds.size() == 0) begin
      $display("vertex_pair_dedup_top test passed");
    end else begin
      $display("vertex_pair_dedup_top test failed");
    end
    $finish;
  end

endmodule

### vertex_pair_dedup_top.f
hw/rtl/vpd_pkg.sv
hw/rtl/vpd_ram.sv
hw/rtl/vpd_cell.sv
hw/rtl/vertex_pair_dedup_top.sv
dv/tb_vertex_pair_dedup_top.sv
